/* hdl/i2c_master_byte_engine_assert.svh */
// ----------------------------------------------------------------------------
// I2C master byte engine assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
`define I2C_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
`define I2C_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define I2C_ASSERT(lbl, clk, rst_n, prop, msg)
`define I2C_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* hdl/i2cm_pkg.sv */
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Sequencer phase codes, command codes, register indexes and line helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CNT_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRETCH_LIMIT = 2'd1;

    localparam logic [CNT_W-1:0] HALF_PERIOD_RST   = 16'd100;
    localparam logic [CNT_W-1:0] STRETCH_LIMIT_RST = 16'd2000;

    typedef enum logic [2:0] {
        FN_START      = 3'd0,
        FN_STOP       = 3'd1,
        FN_WRITE      = 3'd2,
        FN_READ_ACK   = 3'd3,
        FN_READ_NACK  = 3'd4
    } t_func;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_ST_SETUP = 5'd1,
        PH_ST_SDA   = 5'd2,
        PH_ST_SCL   = 5'd3,
        PH_SP_SDA   = 5'd4,
        PH_SP_WAIT  = 5'd5,
        PH_SP_HOLD  = 5'd6,
        PH_SP_REL   = 5'd7,
        PH_WR_LOW   = 5'd8,
        PH_WR_BIT   = 5'd9,
        PH_WR_WAIT  = 5'd10,
        PH_WR_HIGH  = 5'd11,
        PH_WR_FALL  = 5'd12,
        PH_WA_REL   = 5'd13,
        PH_WA_WAIT  = 5'd14,
        PH_WA_HIGH  = 5'd15,
        PH_WA_FALL  = 5'd16,
        PH_RD_LOW   = 5'd17,
        PH_RD_WAIT  = 5'd18,
        PH_RD_HIGH  = 5'd19,
        PH_RD_FALL  = 5'd20,
        PH_RA_DRV   = 5'd21,
        PH_RA_WAIT  = 5'd22,
        PH_RA_HIGH  = 5'd23,
        PH_RA_FALL  = 5'd24
    } t_phase;

    // bit 0: SCL released, bit 1: SDA released
    typedef logic [1:0] t_lines;

    typedef struct packed {
        logic        stretch_timeout;
        logic        nack;
        logic [7:0]  rx_byte;
        logic        done_res;
        logic        busy_res;
        logic        sda_release;
        logic        scl_release;
    } t_result;

    function automatic logic f_is_wait(t_phase p);
        return (p == PH_SP_WAIT) || (p == PH_WR_WAIT) || (p == PH_WA_WAIT) ||
               (p == PH_RD_WAIT) || (p == PH_RA_WAIT);
    endfunction

    // Line levels set on entry to a phase.
    function automatic t_lines f_enter_lines(t_phase p, t_lines cur, logic msb, logic mack);
        t_lines l;
        l = cur;
        unique case (p)
            PH_ST_SETUP: l = 2'b11;
            PH_ST_SDA, PH_SP_SDA: l[1] = 1'b0;
            PH_ST_SCL, PH_WR_LOW, PH_WR_FALL, PH_WA_FALL, PH_RD_FALL: l[0] = 1'b0;
            PH_SP_WAIT, PH_WR_WAIT, PH_WA_WAIT, PH_RD_WAIT, PH_RA_WAIT: l[0] = 1'b1;
            PH_SP_REL, PH_WA_REL: l[1] = 1'b1;
            PH_WR_BIT: l[1] = msb;
            PH_RD_LOW, PH_RA_FALL: l = 2'b10;
            PH_RA_DRV: l = {~mack, 1'b0};
            default: l = cur;
        endcase
        return l;
    endfunction

endpackage

`default_nettype wire

/* hdl/i2c_master_byte_engine.sv */
// ----------------------------------------------------------------------------
// I2C master byte engine
// Start, stop, byte write with ACK sample and byte read with ACK/NACK,
// stepped one bus sample per request, with SCL stretch wait and timeout.
// ----------------------------------------------------------------------------
// An accepted request is held in the input register, then the step writes its result to the output register.
// Throughput: one request per cycle while the result stream is not stalled; the sequencer
// step is a single pass between the input register and the result register.
// Reset (synchronous, active low): idle, both lines released, flags and
// received byte cleared, half_period 100, stretch_limit 2000.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_byte_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    // request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // [7:0] tx_byte, [8] scl_in, [9] sda_in, rest 0
    input  wire logic [3:0]  s_axis_tuser,  // [0] cmd_valid, [3:1] func
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata   // [0] scl_release, [1] sda_release,
                                            // [2] busy_res, [3] done_res,
                                            // [11:4] rx_byte, [12] nack,
                                            // [13] stretch_timeout, rest 0
);

    `include "i2c_master_byte_engine_assert.svh"

    // config
    logic [15:0] r_half_period;
    logic [15:0] r_stretch_limit;

    // input stage
    logic        r_in_vld;
    logic        r_cmd_valid;
    logic [2:0]  r_func;
    logic [7:0]  r_tx_byte;
    logic        r_scl_in;
    logic        r_sda_in;

    // sequencer state
    i2cm_pkg::t_phase r_phase,  n_phase;
    logic [2:0]       r_bit,    n_bit;
    logic [15:0]      r_delay,  n_delay;
    logic [15:0]      r_stretch, n_stretch;
    logic [7:0]       r_shift,  n_shift;
    logic             r_ack,    n_ack;
    logic             r_tmo,    n_tmo;
    i2cm_pkg::t_lines r_line,   n_line;
    logic [7:0]       r_rx,     n_rx;
    logic             r_mack,   n_mack;
    logic             w_done;

    // output stage
    logic              r_out_vld;
    i2cm_pkg::t_result r_res;
    i2cm_pkg::t_result w_res;

    logic w_adv;
    logic w_step;

    assign o_cfg_ready   = 1'b1;
    assign w_adv         = !r_out_vld || m_axis_tready;
    assign w_step        = r_in_vld && w_adv;
    assign s_axis_tready = !r_in_vld || w_adv;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {2'b00, r_res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period   <= i2cm_pkg::HALF_PERIOD_RST;
            r_stretch_limit <= i2cm_pkg::STRETCH_LIMIT_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == i2cm_pkg::CFG_HALF_PERIOD) begin
                r_half_period <= i_cfg_data;
            end
            if (i_cfg_index == i2cm_pkg::CFG_STRETCH_LIMIT) begin
                r_stretch_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd_valid <= s_axis_tuser[0];
            r_func      <= s_axis_tuser[3:1];
            r_tx_byte   <= s_axis_tdata[7:0];
            r_scl_in    <= s_axis_tdata[8];
            r_sda_in    <= s_axis_tdata[9];
        end
    end

    // next state
    always_comb begin
        logic             adv;
        logic             ent;
        i2cm_pkg::t_phase ent_ph;
        logic [15:0]      hp;
        logic [15:0]      dly_inc;

        n_phase   = r_phase;
        n_bit     = r_bit;
        n_delay   = r_delay;
        n_stretch = r_stretch;
        n_shift   = r_shift;
        n_ack     = r_ack;
        n_tmo     = r_tmo;
        n_line    = r_line;
        n_rx      = r_rx;
        n_mack    = r_mack;
        w_done    = 1'b0;
        adv       = 1'b0;
        ent       = 1'b0;
        ent_ph    = i2cm_pkg::PH_IDLE;
        hp        = (r_half_period == 16'd0) ? 16'd1 : r_half_period;
        dly_inc   = r_delay + 16'd1;

        if (r_phase == i2cm_pkg::PH_IDLE || r_phase > i2cm_pkg::PH_RA_FALL) begin
            n_phase = i2cm_pkg::PH_IDLE;
            if (r_cmd_valid && r_func <= i2cm_pkg::FN_READ_NACK) begin
                n_tmo = 1'b0;
                n_bit = 3'd7;
                ent   = 1'b1;
                unique case (i2cm_pkg::t_func'(r_func))
                    i2cm_pkg::FN_START: ent_ph = i2cm_pkg::PH_ST_SETUP;
                    i2cm_pkg::FN_STOP:  ent_ph = i2cm_pkg::PH_SP_SDA;
                    i2cm_pkg::FN_WRITE: begin
                        n_ack   = 1'b0;
                        n_shift = r_tx_byte;
                        ent_ph  = i2cm_pkg::PH_WR_LOW;
                    end
                    default: begin
                        n_mack  = (r_func == i2cm_pkg::FN_READ_ACK);
                        n_shift = 8'd0;
                        ent_ph  = i2cm_pkg::PH_RD_LOW;
                    end
                endcase
            end
        end else if (i2cm_pkg::f_is_wait(r_phase)) begin
            if (r_scl_in) begin
                adv = 1'b1;
            end else if (r_stretch >= r_stretch_limit) begin
                n_tmo = 1'b1;
                if (r_phase == i2cm_pkg::PH_WA_WAIT) begin
                    n_ack     = 1'b1;
                    n_line[0] = 1'b0;
                    n_phase   = i2cm_pkg::PH_IDLE;
                    w_done    = 1'b1;
                end else begin
                    adv = 1'b1;
                end
            end else begin
                n_stretch = r_stretch + 16'd1;
            end
        end else begin
            n_delay = dly_inc;
            adv     = (dly_inc >= hp);
        end

        if (adv) begin
            unique case (r_phase)
                i2cm_pkg::PH_ST_SCL, i2cm_pkg::PH_SP_REL,
                i2cm_pkg::PH_WA_FALL, i2cm_pkg::PH_RA_FALL: begin
                    n_phase = i2cm_pkg::PH_IDLE;
                    w_done  = 1'b1;
                end
                i2cm_pkg::PH_WR_FALL: begin
                    ent = 1'b1;
                    if (r_bit == 3'd0) begin
                        ent_ph = i2cm_pkg::PH_WA_REL;
                    end else begin
                        n_bit   = r_bit - 3'd1;
                        n_shift = {r_shift[6:0], 1'b0};
                        ent_ph  = i2cm_pkg::PH_WR_LOW;
                    end
                end
                i2cm_pkg::PH_WA_HIGH: begin
                    n_ack  = r_sda_in;
                    ent    = 1'b1;
                    ent_ph = i2cm_pkg::PH_WA_FALL;
                end
                i2cm_pkg::PH_RD_HIGH: begin
                    n_shift = {r_shift[6:0], r_sda_in};
                    ent     = 1'b1;
                    ent_ph  = i2cm_pkg::PH_RD_FALL;
                end
                i2cm_pkg::PH_RD_FALL: begin
                    ent = 1'b1;
                    if (r_bit == 3'd0) begin
                        n_rx   = r_shift;
                        ent_ph = i2cm_pkg::PH_RA_DRV;
                    end else begin
                        n_bit  = r_bit - 3'd1;
                        ent_ph = i2cm_pkg::PH_RD_LOW;
                    end
                end
                default: begin
                    ent    = 1'b1;
                    ent_ph = i2cm_pkg::t_phase'(r_phase + 5'd1);
                end
            endcase
        end

        if (ent) begin
            n_phase   = ent_ph;
            n_delay   = 16'd0;
            n_stretch = 16'd0;
            n_line    = i2cm_pkg::f_enter_lines(ent_ph, n_line, n_shift[7], n_mack);
        end
    end

    // result
    always_comb begin
        w_res.scl_release     = n_line[0];
        w_res.sda_release     = n_line[1];
        w_res.busy_res        = (n_phase != i2cm_pkg::PH_IDLE);
        w_res.done_res        = w_done;
        w_res.rx_byte         = n_rx;
        w_res.nack            = n_ack;
        w_res.stretch_timeout = n_tmo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= i2cm_pkg::PH_IDLE;
            r_bit     <= 3'd0;
            r_delay   <= 16'd0;
            r_stretch <= 16'd0;
            r_shift   <= 8'd0;
            r_ack     <= 1'b0;
            r_tmo     <= 1'b0;
            r_line    <= 2'b11;
            r_rx      <= 8'd0;
            r_mack    <= 1'b0;
        end else if (w_step) begin
            r_phase   <= n_phase;
            r_bit     <= n_bit;
            r_delay   <= n_delay;
            r_stretch <= n_stretch;
            r_shift   <= n_shift;
            r_ack     <= n_ack;
            r_tmo     <= n_tmo;
            r_line    <= n_line;
            r_rx      <= n_rx;
            r_mack    <= n_mack;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_res <= w_res;
        end
    end

    `I2C_ASSERT(a_done_not_busy, i_clk, i_rst_n, (r_out_vld && r_res.done_res) |-> !r_res.busy_res, "done with busy set")
    `I2C_ASSERT(a_stretch_in_wait, i_clk, i_rst_n, (r_stretch != 16'd0) |-> (i2cm_pkg::f_is_wait(r_phase) || r_phase == i2cm_pkg::PH_IDLE), "stretch count outside wait")
    `I2C_ASSERT(a_delay_in_delay, i_clk, i_rst_n, (r_delay != 16'd0) |-> !i2cm_pkg::f_is_wait(r_phase), "delay count in a wait phase")
    `I2C_ASSERT(a_hold_no_step, i_clk, i_rst_n, !w_step |=> $stable(r_phase) && $stable(r_line), "state moved without a step")

endmodule

`default_nettype wire
